@@ rtl/core/pswfs_pkg.sv @@
package pswfs_pkg;

  localparam int MAX_PREAMBLE_BYTES = 8;
  localparam int MAX_SYNC_BYTES     = 4;
  localparam int LENGTH_BITS        = 16;
  localparam int QUEUE_DEPTH        = 2;

  localparam int REG_INDEX_W = 3;
  localparam logic [REG_INDEX_W-1:0] REG_MODULATION       = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PREAMBLE_PATTERN = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_PREAMBLE_BYTES   = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_SYNC_PATTERN     = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_SYNC_BYTES       = 3'd4;

  localparam logic [7:0] PREAMBLE_PATTERN_RST = 8'd170;
  localparam logic [3:0] PREAMBLE_BYTES_RST   = 4'd8;
  localparam logic [2:0] SYNC_BYTES_RST       = 3'd4;

  typedef struct packed {
    logic pre_shift;
    logic sync_shift;
    logic sync_clear;
  } corr_ctl_t;

  typedef struct packed {
    logic       pre_hit;
    logic       sync_hit;
    logic [1:0] sync_rot;
  } corr_stat_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [15:0] frame_bytes;
  } res_t;

  // Gray map {0,1,3,2}; it is its own inverse
  function automatic logic [1:0] gray2(input logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  function automatic logic [1:0] rot_sym(input logic [1:0] v, input logic [1:0] k);
    logic [1:0] idx;
    idx = gray2(v) + k;
    return gray2(idx);
  endfunction

  function automatic logic [1:0] derot_sym(input logic [1:0] v, input logic [1:0] k);
    logic [1:0] idx;
    idx = gray2(v) - k;
    return gray2(idx);
  endfunction

  function automatic logic [31:0] rot_word(input logic [31:0] w, input logic [1:0] k);
    logic [31:0] r;
    for (int p = 0; p < 16; p++) begin
      r[2*p +: 2] = rot_sym(w[2*p +: 2], k);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pswfs_corr.sv @@
module pswfs_corr #(
  parameter int MAX_PREAMBLE_BYTES = pswfs_pkg::MAX_PREAMBLE_BYTES,
  parameter int MAX_SYNC_BYTES     = pswfs_pkg::MAX_SYNC_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pswfs_pkg::corr_ctl_t  ctl,
  input  logic [1:0]            sym,
  input  logic                  qpsk,
  input  logic [7:0]            pre_pattern,
  input  logic [3:0]            pre_len,
  input  logic [31:0]           sync_pattern,
  input  logic [2:0]            sync_len,
  output pswfs_pkg::corr_stat_t stat
);

  localparam int PW = MAX_PREAMBLE_BYTES * 8;
  localparam int SB = (MAX_SYNC_BYTES > 4) ? 4 : MAX_SYNC_BYTES;
  localparam int SW = SB * 8;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] pre_win;
  logic [PW-1:0] pre_win_next;
  logic [PW-1:0] diff;
  logic [3:0]    lane_cnt [MAX_PREAMBLE_BYTES];
  logic [CW-1:0] ham_dist;
  logic [CW-1:0] target;
  logic          pre_hit;

  logic [SW-1:0] sync_win;
  logic [SW-1:0] sync_win_next;
  logic [SW-1:0] smask;
  logic [SW-1:0] w;
  logic [SW-1:0] t0;
  logic [31:0]   r1;
  logic [31:0]   r2;
  logic [31:0]   r3;

  // preamble: Hamming distance per byte lane, summed over the lanes in use
  always_comb begin
    pre_win_next = qpsk ? {pre_win[PW-3:0], sym} : {pre_win[PW-2:0], sym[0]};
    diff = pre_win_next ^ {MAX_PREAMBLE_BYTES{pre_pattern}};
    for (int l = 0; l < MAX_PREAMBLE_BYTES; l++) begin
      lane_cnt[l] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        lane_cnt[l] = lane_cnt[l] + 4'(diff[l*8 + b]);
      end
    end
    ham_dist = '0;
    for (int l = 0; l < MAX_PREAMBLE_BYTES; l++) begin
      if (pre_len > 4'(l)) begin
        ham_dist = ham_dist + CW'(lane_cnt[l]);
      end
    end
    target = CW'({pre_len, 2'b00});
    pre_hit = (ham_dist == target);
  end

  // sync word: exact match against each allowed rotation, normal first
  always_comb begin
    stat.pre_hit = pre_hit;
    sync_win_next = qpsk ? {sync_win[SW-3:0], sym} : {sync_win[SW-2:0], sym[0]};
    for (int j = 0; j < SB; j++) begin
      smask[j*8 +: 8] = {8{sync_len > 3'(j)}};
    end
    r1 = pswfs_pkg::rot_word(sync_pattern, 2'd1);
    r2 = pswfs_pkg::rot_word(sync_pattern, 2'd2);
    r3 = pswfs_pkg::rot_word(sync_pattern, 2'd3);
    t0 = sync_pattern[SW-1:0] & smask;
    w  = sync_win_next & smask;
    stat.sync_hit = 1'b1;
    stat.sync_rot = 2'd0;
    if (w == t0) begin
      stat.sync_rot = 2'd0;
    end else if (!qpsk) begin
      stat.sync_rot = 2'd2;
      stat.sync_hit = (w == (~t0 & smask));
    end else if (w == (r2[SW-1:0] & smask)) begin
      stat.sync_rot = 2'd2;
    end else if (w == (r1[SW-1:0] & smask)) begin
      stat.sync_rot = 2'd1;
    end else if (w == (r3[SW-1:0] & smask)) begin
      stat.sync_rot = 2'd3;
    end else begin
      stat.sync_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_win  <= '0;
      sync_win <= '0;
    end else begin
      if (ctl.pre_shift) begin
        pre_win <= pre_win_next;
      end
      if (ctl.sync_clear) begin
        sync_win <= '0;
      end else if (ctl.sync_shift) begin
        sync_win <= sync_win_next;
      end
    end
  end

endmodule

@@ rtl/core/pswfs_front.sv @@
module pswfs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            sym,
  input  logic                  qpsk,
  input  pswfs_pkg::corr_stat_t stat,
  output pswfs_pkg::corr_ctl_t  ctl,
  output logic                  res_push,
  output pswfs_pkg::res_t       res
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_SYNC = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_PAY  = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [1:0]  rotation, rotation_next;
  logic [15:0] length_shift, length_shift_next;
  logic [4:0]  length_bit_count, length_bit_count_next;
  logic [2:0]  bit_cnt, bit_cnt_next;
  logic [15:0] byte_cnt, byte_cnt_next;
  logic [7:0]  byte_assembler, byte_assembler_next;

  logic [1:0]  d;
  logic [15:0] len_shifted;
  logic [4:0]  len_cnt_inc;
  logic        b_hi;
  logic [7:0]  asm1, asm2;
  logic [2:0]  bc1, bc2;
  logic        done1, done2, take2, last, emit;

  always_comb begin
    d = qpsk ? pswfs_pkg::derot_sym(sym, rotation) : {1'b0, sym[0] ^ rotation[1]};
    len_shifted = qpsk ? {length_shift[13:0], d} : {length_shift[14:0], d[0]};
    len_cnt_inc = length_bit_count + (qpsk ? 5'd2 : 5'd1);

    // payload packing: up to two bits per beat, stop at the frame's final byte
    b_hi  = qpsk ? d[1] : d[0];
    asm1  = {byte_assembler[6:0], b_hi};
    bc1   = bit_cnt + 3'd1;
    done1 = (bc1 == 3'd0);
    last  = ((byte_cnt + 16'd1) == length_shift);
    take2 = qpsk && !(done1 && last);
    asm2  = {asm1[6:0], d[0]};
    bc2   = take2 ? bc1 + 3'd1 : bc1;
    done2 = take2 && (bc2 == 3'd0);
    emit  = done1 || done2;
  end

  always_comb begin
    phase_next            = phase;
    rotation_next         = rotation;
    length_shift_next     = length_shift;
    length_bit_count_next = length_bit_count;
    bit_cnt_next          = bit_cnt;
    byte_cnt_next         = byte_cnt;
    byte_assembler_next   = byte_assembler;
    ctl                   = '0;
    res_push              = 1'b0;
    res.payload_byte      = done1 ? asm1 : asm2;
    res.last_of_frame     = last;
    res.frame_bytes       = length_shift;

    unique case (phase)
      PH_SYNC: begin
        ctl.sync_shift = accept;
        if (accept && stat.sync_hit) begin
          rotation_next         = stat.sync_rot;
          phase_next            = PH_LEN;
          length_shift_next     = '0;
          length_bit_count_next = '0;
        end
      end
      PH_LEN: begin
        if (accept) begin
          length_shift_next     = len_shifted;
          length_bit_count_next = len_cnt_inc;
          if (len_cnt_inc >= 5'(pswfs_pkg::LENGTH_BITS)) begin
            bit_cnt_next        = '0;
            byte_cnt_next       = '0;
            byte_assembler_next = '0;
            phase_next          = (len_shifted == 16'd0) ? PH_SKIP : PH_PAY;
          end
        end
      end
      PH_PAY: begin
        if (accept) begin
          byte_assembler_next = take2 ? asm2 : asm1;
          bit_cnt_next        = bc2;
          res_push            = emit;
          if (emit) begin
            byte_cnt_next = byte_cnt + 16'd1;
            if (last) begin
              phase_next = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (accept) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        // unused codes hunt like the preamble hunt
        ctl.pre_shift = accept;
        if (accept) begin
          phase_next = PH_HUNT;
          if (stat.pre_hit) begin
            phase_next     = PH_SYNC;
            ctl.sync_clear = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      rotation         <= '0;
      length_shift     <= '0;
      length_bit_count <= '0;
      bit_cnt          <= '0;
      byte_cnt         <= '0;
      byte_assembler   <= '0;
    end else begin
      phase            <= phase_next;
      rotation         <= rotation_next;
      length_shift     <= length_shift_next;
      length_bit_count <= length_bit_count_next;
      bit_cnt          <= bit_cnt_next;
      byte_cnt         <= byte_cnt_next;
      byte_assembler   <= byte_assembler_next;
    end
  end

  a_push_in_pay: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (phase == PH_PAY && accept))
    else $error("result pushed outside payload");

  a_last_skips: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last_of_frame) |=> (phase == PH_SKIP))
    else $error("final byte did not end the frame");

  a_skip_one: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP && accept) |=> (phase == PH_HUNT))
    else $error("skip lasted more than one beat");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (length_shift != 16'd0 && byte_cnt < length_shift))
    else $error("payload count out of range");

endmodule

@@ rtl/core/pswfs_queue.sv @@
module pswfs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pswfs_pkg::res_t din,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pswfs_pkg::res_t dout
);

  localparam int DEPTH = pswfs_pkg::QUEUE_DEPTH;
  localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  pswfs_pkg::res_t mem [DEPTH];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full result queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("result queue count overflow");

endmodule

@@ rtl/core/preamble_sync_word_frame_sync.sv @@
// Frame synchronizer for BPSK/QPSK symbols. One symbol is taken per clock
// unless full: every symbol is classified and consumed in the cycle it is
// accepted (window shift plus preamble distance and sync compare, length gather
// or payload packing), and each finished payload byte goes into a two-beat
// result queue. full only rises while that queue holds two bytes, so with pop
// kept high the block sustains one symbol per cycle; a byte shows on the result
// side in the cycle after the symbol that completes it. After a preamble hit
// (distance of exactly half the compared bits) the sync word is searched in all
// allowed phase rotations, the rotation is latched, 16 length bits follow, then
// the payload; one symbol is skipped after each frame. Registers are written
// through wr_en/wr_index/wr_data and must only change while the block is idle.
module preamble_sync_word_frame_sync #(
  parameter int MAX_PREAMBLE_BYTES = pswfs_pkg::MAX_PREAMBLE_BYTES,
  parameter int MAX_SYNC_BYTES     = pswfs_pkg::MAX_SYNC_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        symbol,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        payload_byte,
  output logic                              last_of_frame,
  output logic [15:0]                       frame_bytes,
  input  logic                              wr_en,
  input  logic [pswfs_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [31:0]                       wr_data
);

  localparam int SB_EFF = (MAX_SYNC_BYTES > 4) ? 4 : MAX_SYNC_BYTES;

  logic        modulation;
  logic [7:0]  preamble_pattern;
  logic [3:0]  preamble_bytes;
  logic [31:0] sync_pattern;
  logic [2:0]  sync_bytes;

  logic [3:0] pre_len;
  logic [2:0] sync_len;
  logic       accept;
  logic       res_push;

  pswfs_pkg::corr_ctl_t  ctl;
  pswfs_pkg::corr_stat_t stat;
  pswfs_pkg::res_t       res;
  pswfs_pkg::res_t       res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulation       <= 1'b0;
      preamble_pattern <= pswfs_pkg::PREAMBLE_PATTERN_RST;
      preamble_bytes   <= pswfs_pkg::PREAMBLE_BYTES_RST;
      sync_pattern     <= '0;
      sync_bytes       <= pswfs_pkg::SYNC_BYTES_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        pswfs_pkg::REG_MODULATION:       modulation       <= wr_data[0];
        pswfs_pkg::REG_PREAMBLE_PATTERN: preamble_pattern <= wr_data[7:0];
        pswfs_pkg::REG_PREAMBLE_BYTES:   preamble_bytes   <= wr_data[3:0];
        pswfs_pkg::REG_SYNC_PATTERN:     sync_pattern     <= wr_data;
        pswfs_pkg::REG_SYNC_BYTES:       sync_bytes       <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (preamble_bytes == 4'd0) begin
      pre_len = 4'd1;
    end else if (preamble_bytes > 4'(MAX_PREAMBLE_BYTES)) begin
      pre_len = 4'(MAX_PREAMBLE_BYTES);
    end else begin
      pre_len = preamble_bytes;
    end
    if (sync_bytes == 3'd0) begin
      sync_len = 3'd1;
    end else if (sync_bytes > 3'(SB_EFF)) begin
      sync_len = 3'(SB_EFF);
    end else begin
      sync_len = sync_bytes;
    end
  end

  assign accept = push && !full;

  pswfs_corr #(
    .MAX_PREAMBLE_BYTES(MAX_PREAMBLE_BYTES),
    .MAX_SYNC_BYTES    (MAX_SYNC_BYTES)
  ) u_corr (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sym         (symbol),
    .qpsk        (modulation),
    .pre_pattern (preamble_pattern),
    .pre_len     (pre_len),
    .sync_pattern(sync_pattern),
    .sync_len    (sync_len),
    .stat        (stat)
  );

  pswfs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .sym     (symbol),
    .qpsk    (modulation),
    .stat    (stat),
    .ctl     (ctl),
    .res_push(res_push),
    .res     (res)
  );

  pswfs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (full),
    .pop  (pop),
    .empty(empty),
    .dout (res_out)
  );

  assign payload_byte  = res_out.payload_byte;
  assign last_of_frame = res_out.last_of_frame;
  assign frame_bytes   = res_out.frame_bytes;

endmodule
